/* rtl/lkv_pkg.sv */
// Shared constants, types and controller encodings for the LRU key/value cache.
package lkv_pkg;

	localparam int ENTRIES   = 16;
	localparam int DATA_W    = 32;
	localparam int CAP_W     = 5;
	localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W     = $clog2(ENTRIES + 1);
	localparam int CMP_W     = (CAP_W > CNT_W) ? CAP_W : CNT_W;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_END,
		ST_DECIDE,
		ST_GET_RD,
		ST_GET_RES,
		ST_PUT_UPD,
		ST_EV_RD,
		ST_EV_CLR,
		ST_INSERT
	} lkv_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic decide;
		logic rd_val;
		logic get_res;
		logic put_upd;
		logic ev_rd;
		logic ev_clr;
		logic insert;
		logic done;
	} lkv_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last;
		logic found;
		logic is_put;
		logic need_evict;
	} lkv_status_t;

endpackage

/* rtl/lkv_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lkv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/lkv_ctrl.sv */
// Controller state machine: sequences scan, lookup, eviction and insert steps.
module lkv_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  lkv_pkg::lkv_status_t status,
	output lkv_pkg::lkv_cmd_t   cmd
);
	import lkv_pkg::*;

	lkv_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_last) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				if (!status.is_put) begin
					if (status.found) begin
						state_d = ST_GET_RD;
					end else begin
						cmd.done = 1'b1;
						state_d  = ST_IDLE;
					end
				end else if (status.found) begin
					state_d = ST_PUT_UPD;
				end else if (status.need_evict) begin
					state_d = ST_EV_RD;
				end else begin
					state_d = ST_INSERT;
				end
			end
			ST_GET_RD: begin
				cmd.rd_val = 1'b1;
				state_d    = ST_GET_RES;
			end
			ST_GET_RES: begin
				cmd.get_res = 1'b1;
				cmd.done    = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_PUT_UPD: begin
				cmd.put_upd = 1'b1;
				cmd.done    = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_EV_RD: begin
				cmd.ev_rd = 1'b1;
				state_d   = ST_EV_CLR;
			end
			ST_EV_CLR: begin
				cmd.ev_clr = 1'b1;
				state_d    = ST_INSERT;
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				cmd.done   = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/lkv_datapath.sv */
// Datapath: key/value RAMs, valid and rank flops, scan trackers, result registers.
module lkv_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lkv_pkg::lkv_cmd_t                 cmd,
	output lkv_pkg::lkv_status_t              status,
	input  logic                              in_op,
	input  logic [lkv_pkg::DATA_W-1:0]        in_key,
	input  logic [lkv_pkg::DATA_W-1:0]        in_value,
	input  logic                              cfg_we,
	input  logic [lkv_pkg::CAP_W-1:0]         cfg_wdata,
	output logic                              res_done,
	output logic                              res_hit,
	output logic [lkv_pkg::DATA_W-1:0]        res_rd,
	output logic                              res_ev,
	output logic [lkv_pkg::DATA_W-1:0]        res_evk
);
	import lkv_pkg::*;

	// request
	logic              op_q;
	logic [DATA_W-1:0] key_q, val_q;

	// scan
	logic [IDX_W-1:0] idx_q, idx_s1;
	logic             scan_s1;
	logic             found_q, vfound_q, ffound_q;
	logic [IDX_W-1:0] slot_q, victim_q, free_q, best_q;

	// state
	logic [CAP_W-1:0] cap_q;
	logic [CNT_W-1:0] count_q;
	logic             valid_q [ENTRIES];
	logic [IDX_W-1:0] rank_q  [ENTRIES];

	// RAM ports
	logic              key_we, val_we;
	logic [IDX_W-1:0]  waddr, raddr;
	logic [DATA_W-1:0] key_rdata, val_rdata;

	logic [CMP_W-1:0] eff_cap;
	logic             key_match;
	logic [IDX_W-1:0] promo_rank;
	logic             promote;

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CMP_W'(1);
		end else if (CMP_W'(cap_q) > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = CMP_W'(cap_q);
		end
	end

	assign status.scan_last  = (idx_q == IDX_W'(ENTRIES - 1));
	assign status.found      = found_q;
	assign status.is_put     = (op_q == OP_PUT);
	assign status.need_evict = (CMP_W'(count_q) >= eff_cap) && vfound_q;

	always_comb begin
		if (cmd.rd_val) begin
			raddr = slot_q;
		end else if (cmd.ev_rd) begin
			raddr = victim_q;
		end else begin
			raddr = idx_q;
		end
	end

	assign key_we = cmd.insert;
	assign val_we = cmd.insert | cmd.put_upd;
	assign waddr  = cmd.insert ? free_q : slot_q;

	lkv_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (waddr),
		.wdata (key_q),
		.raddr (raddr),
		.rdata (key_rdata)
	);

	lkv_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (waddr),
		.wdata (val_q),
		.raddr (raddr),
		.rdata (val_rdata)
	);

	// request capture and scan trackers
	assign key_match = scan_s1 && valid_q[idx_s1] && (key_rdata == key_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= in_op;
			key_q    <= in_key;
			val_q    <= in_value;
			found_q  <= 1'b0;
			vfound_q <= 1'b0;
			ffound_q <= 1'b0;
		end else begin
			if (key_match && !found_q) begin
				found_q <= 1'b1;
				slot_q  <= idx_s1;
			end
			// last entry with the largest rank wins
			if (scan_s1 && valid_q[idx_s1] && (!vfound_q || rank_q[idx_s1] >= best_q)) begin
				vfound_q <= 1'b1;
				victim_q <= idx_s1;
				best_q   <= rank_q[idx_s1];
			end
			if (scan_s1 && !valid_q[idx_s1] && !ffound_q) begin
				ffound_q <= 1'b1;
				free_q   <= idx_s1;
			end
			// evicted slot becomes free; keep the lowest free index
			if (cmd.ev_clr && (!ffound_q || victim_q < free_q)) begin
				ffound_q <= 1'b1;
				free_q   <= victim_q;
			end
		end
		if (cmd.load) begin
			idx_q <= '0;
		end else if (cmd.scan) begin
			idx_q <= idx_q + IDX_W'(1);
		end
		idx_s1 <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_s1 <= 1'b0;
		end else begin
			scan_s1 <= cmd.scan;
		end
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// valid bits, recency ranks, fill count
	assign promote    = cmd.get_res | cmd.put_upd;
	assign promo_rank = rank_q[slot_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				rank_q[i]  <= '0;
			end
		end else begin
			if (promote) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (IDX_W'(i) == slot_q) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && rank_q[i] < promo_rank) begin
						rank_q[i] <= rank_q[i] + IDX_W'(1);
					end
				end
			end
			if (cmd.ev_clr) begin
				valid_q[victim_q] <= 1'b0;
				rank_q[victim_q]  <= '0;
				count_q           <= count_q - CNT_W'(1);
			end
			if (cmd.insert) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (IDX_W'(i) == free_q) begin
						valid_q[i] <= 1'b1;
						rank_q[i]  <= '0;
					end else if (valid_q[i]) begin
						rank_q[i] <= rank_q[i] + IDX_W'(1);
					end
				end
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			res_hit <= found_q;
			res_rd  <= (op_q == OP_GET && !found_q) ? '1 : '0;
			res_ev  <= 1'b0;
			res_evk <= '0;
		end
		if (cmd.get_res) begin
			res_rd <= val_rdata;
		end
		if (cmd.ev_clr) begin
			res_ev  <= 1'b1;
			res_evk <= key_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_done <= 1'b0;
		end else begin
			res_done <= cmd.done;
		end
	end

endmodule

/* rtl/lru_key_value_cache_unit.sv */
// Top level of the fully associative LRU key/value cache.
//
// Usage:
//  - Command channel: drive op/key/value and raise start while busy is low;
//    the transaction is taken at that clock edge. op 0 = get, op 1 = put.
//  - Result: done pulses high for exactly one cycle with hit, read_value,
//    evicted and evicted_key. The receiver cannot stall; results must be
//    taken in that cycle.
//  - Config: cfg_valid/cfg_ready write the 5-bit capacity (cfg_ready is
//    always high). 0 acts as 1, values above 16 act as 16.
//    Write only while busy is low and no result is pending.
// Timing: busy rises the cycle after start. The controller walks all 16
//  entries through one RAM read port, one entry per cycle, then runs the
//  decide, lookup, evict and insert steps that the operation needs. The
//  next start is accepted in the cycle done is high; a new transaction is
//  taken only once the last one is through, and the sequential 16-entry
//  key scan sets the throughput.
// Reset: arst_n clears all valid bits, ranks, fill count and the controller;
//  capacity returns to 16. No clearing pass is needed.
module lru_key_value_cache_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 op,
	input  logic signed [lkv_pkg::DATA_W-1:0]    key,
	input  logic signed [lkv_pkg::DATA_W-1:0]    value,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lkv_pkg::CAP_W-1:0]            cfg_data,
	output logic                                 done,
	output logic                                 hit,
	output logic signed [lkv_pkg::DATA_W-1:0]    read_value,
	output logic                                 evicted,
	output logic signed [lkv_pkg::DATA_W-1:0]    evicted_key
);
	import lkv_pkg::*;

	lkv_cmd_t    cmd;
	lkv_status_t status;

	logic [DATA_W-1:0] rd_raw, evk_raw;

	// capacity writes are always taken
	assign cfg_ready = 1'b1;

	lkv_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	lkv_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_op     (op),
		.in_key    (key),
		.in_value  (value),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_wdata (cfg_data),
		.res_done  (done),
		.res_hit   (hit),
		.res_rd    (rd_raw),
		.res_ev    (evicted),
		.res_evk   (evk_raw)
	);

	assign read_value  = signed'(rd_raw);
	assign evicted_key = signed'(evk_raw);

endmodule

/* tb/lru_key_value_cache_unit_test.sv */
// Self-checking testbench for the LRU key/value cache: directed and random gets/puts.
`timescale 1ns / 100ps

module lru_key_value_cache_unit_test;

	import lkv_pkg::*;

	// Generous ceiling: many times what about 1000 transactions need.
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 950;
	localparam int POOL_MAX     = 24;
	localparam int DRAIN_CYCLES = 30;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic              hit;
		logic [DATA_W-1:0] read_value;
		logic              evicted;
		logic [DATA_W-1:0] evicted_key;
	} cache_result_t;

	// Shadow copy of the cache plus the queue of results still owed by the DUT.
	class cache_scoreboard;
		logic [DATA_W-1:0] slot_key [ENTRIES];
		logic [DATA_W-1:0] slot_val [ENTRIES];
		bit                slot_used [ENTRIES];
		int unsigned       slot_rank [ENTRIES];
		int unsigned       used_count;
		logic [CAP_W-1:0]  capacity;
		cache_result_t     pending [$];
		int                errors;

		function new();
			for (int i = 0; i < ENTRIES; i++) begin
				slot_key[i]  = '0;
				slot_val[i]  = '0;
				slot_used[i] = 1'b0;
				slot_rank[i] = 0;
			end
			used_count = 0;
			capacity   = CAP_RESET;
			errors     = 0;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] c);
			capacity = c;
		endfunction

		// Move slot s to the front; everything that was ahead of it slides back one.
		function void promote(int s);
			int unsigned old_rank;
			old_rank = slot_rank[s];
			for (int i = 0; i < ENTRIES; i++)
				if (slot_used[i] && slot_rank[i] < old_rank)
					slot_rank[i]++;
			slot_rank[s] = 0;
		endfunction

		// Called for every accepted command, in acceptance order.
		function void note_command(logic o, logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
			int            found;
			int            victim;
			int            free_slot;
			int unsigned   oldest;
			int unsigned   eff_cap;
			cache_result_t r;
			found     = -1;
			victim    = -1;
			free_slot = -1;
			oldest    = 0;
			r         = '0;
			for (int i = 0; i < ENTRIES; i++)
				if (found < 0 && slot_used[i] && slot_key[i] == k)
					found = i;
			if (o == OP_GET) begin
				if (found >= 0) begin
					r.hit        = 1'b1;
					r.read_value = slot_val[found];
					promote(found);
				end else begin
					r.read_value = '1;
				end
			end else if (found >= 0) begin
				r.hit           = 1'b1;
				slot_val[found] = v;
				promote(found);
			end else begin
				// zero behaves as one, anything past the array size as the array size
				eff_cap = (capacity == 0) ? 1 : (capacity > ENTRIES) ? ENTRIES : capacity;
				if (used_count >= eff_cap) begin
					// ties go to the highest slot index
					for (int i = 0; i < ENTRIES; i++)
						if (slot_used[i] && (victim < 0 || slot_rank[i] >= oldest)) begin
							victim = i;
							oldest = slot_rank[i];
						end
					if (victim >= 0) begin
						r.evicted         = 1'b1;
						r.evicted_key     = slot_key[victim];
						slot_used[victim] = 1'b0;
						slot_rank[victim] = 0;
						used_count--;
					end
				end
				for (int i = 0; i < ENTRIES; i++)
					if (free_slot < 0 && !slot_used[i])
						free_slot = i;
				if (free_slot >= 0) begin
					for (int i = 0; i < ENTRIES; i++)
						if (slot_used[i])
							slot_rank[i]++;
					slot_used[free_slot] = 1'b1;
					slot_key[free_slot]  = k;
					slot_val[free_slot]  = v;
					slot_rank[free_slot] = 0;
					used_count++;
				end
			end
			pending = {pending, r};
		endfunction

		function void check_result(cache_result_t got);
			cache_result_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("unexpected result: hit=%0b read_value=%h evicted=%0b evicted_key=%h",
						got.hit, got.read_value, got.evicted, got.evicted_key);
				return;
			end
			want = pending.pop_front();
			if (got.hit !== want.hit || got.read_value !== want.read_value ||
			    got.evicted !== want.evicted || got.evicted_key !== want.evicted_key) begin
				errors++;
				if (errors <= REPORT_MAX) begin
					$display("mismatch: expected hit=%0b read_value=%h evicted=%0b evicted_key=%h",
						want.hit, want.read_value, want.evicted, want.evicted_key);
					$display("          got      hit=%0b read_value=%h evicted=%0b evicted_key=%h",
						got.hit, got.read_value, got.evicted, got.evicted_key);
				end
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic                     op;
	logic signed [DATA_W-1:0] key;
	logic signed [DATA_W-1:0] value;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CAP_W-1:0]         cfg_data;
	logic                     done;
	logic                     hit;
	logic signed [DATA_W-1:0] read_value;
	logic                     evicted;
	logic signed [DATA_W-1:0] evicted_key;

	cache_scoreboard sb;
	int              cycles;
	bit              no_gaps;
	logic [DATA_W-1:0] key_pool [POOL_MAX];
	int              pool_size;

	lru_key_value_cache_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.key        (key),
		.value      (value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.done       (done),
		.hit        (hit),
		.read_value (read_value),
		.evicted    (evicted),
		.evicted_key(evicted_key)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: a hung handshake or a missing result ends here.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("lru_key_value_cache_unit test failed");
			$finish;
		end
	end

	// Results cannot be stalled, so every done cycle is a transaction to check.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result('{hit, read_value, evicted, evicted_key});
	end

	// Drive one command from a falling edge once the unit is free, after the
	// drawn idle gap; with no gap the command is up in the done cycle, so
	// back-to-back acceptance is exercised.
	task automatic send_command(input logic o, input logic [DATA_W-1:0] k,
	                            input logic [DATA_W-1:0] v);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		start = 1'b0;
		while (busy !== 1'b0)
			@(negedge clk);
		repeat (gap) @(negedge clk);
		op    = o;
		key   = k;
		value = v;
		start = 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_command(o, k, v);
		@(negedge clk);
	endtask

	// Every command yields a result, so an empty queue means the unit is idle.
	task automatic wait_idle();
		start = 1'b0;
		while (sb.pending.size() != 0 || busy !== 1'b0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] c);
		wait_idle();
		cfg_valid = 1'b1;
		cfg_data  = c;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.set_capacity(c);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Small key pools keep hits and evictions frequent; extremes are mixed in.
	task automatic refill_pool(input int n);
		pool_size = n;
		for (int i = 0; i < n; i++)
			case ($urandom_range(0, 9))
				0:       key_pool[i] = 32'h8000_0000;
				1:       key_pool[i] = 32'h7fff_ffff;
				2:       key_pool[i] = '0;
				3:       key_pool[i] = '1;
				default: key_pool[i] = $urandom();
			endcase
	endtask

	function automatic logic [DATA_W-1:0] draw_key();
		if ($urandom_range(0, 99) < 85)
			return key_pool[$urandom_range(0, pool_size - 1)];
		return $urandom();
	endfunction

	function automatic logic [DATA_W-1:0] draw_value();
		case ($urandom_range(0, 15))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [CAP_W-1:0] pick_capacity(int phase);
		case (phase)
			0:       return 5'd1;
			1:       return 5'd16;
			2:       return 5'd0;
			3:       return 5'd31;
			4:       return 5'd17;
			5:       return 5'd2;
			default: begin
				if ($urandom_range(0, 9) < 6)
					return CAP_W'($urandom_range(1, 6));
				return CAP_W'($urandom_range(0, 31));
			end
		endcase
	endfunction

	initial begin
		int issued;
		int phase;
		int phase_len;
		start     = 1'b0;
		op        = OP_GET;
		key       = '0;
		value     = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		cycles    = 0;
		no_gaps   = 1'b0;
		sb        = new();
		refill_pool(8);

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty-cache miss, extreme keys and values, update of a
		// present key, a stored value equal to the miss marker.
		send_command(OP_GET, 32'h0000_0000, 32'h1234_5678);
		send_command(OP_PUT, 32'h8000_0000, 32'h7fff_ffff);
		send_command(OP_PUT, 32'h7fff_ffff, 32'h8000_0000);
		send_command(OP_GET, 32'h8000_0000, '0);
		send_command(OP_GET, 32'h7fff_ffff, '1);
		send_command(OP_PUT, 32'h8000_0000, 32'h0000_0005);
		send_command(OP_GET, 32'hffff_ffff, '0);
		send_command(OP_PUT, 32'hffff_ffff, 32'hffff_ffff);
		send_command(OP_GET, 32'hffff_ffff, '0);
		send_command(OP_GET, 32'h0000_0000, '0);

		// Capacity dropped below the fill count: each new key evicts just one.
		write_capacity(5'd2);
		send_command(OP_PUT, 32'h0000_0007, 32'haaaa_5555);
		send_command(OP_PUT, 32'h0000_0008, 32'h5555_aaaa);
		send_command(OP_GET, 32'h0000_0007, '0);
		send_command(OP_PUT, 32'h0000_0008, 32'h0000_0001);
		send_command(OP_GET, 32'hffff_ffff, '0);

		// Zero acts as one entry.
		write_capacity(5'd0);
		send_command(OP_PUT, 32'h0000_0009, 32'h0000_0009);
		send_command(OP_PUT, 32'h0000_0009, 32'h0000_000a);
		send_command(OP_GET, 32'h0000_0009, '0);

		// Oversized capacity clamps to the array size.
		write_capacity(5'd31);
		send_command(OP_PUT, 32'h0000_000b, 32'h0000_000b);
		send_command(OP_GET, 32'h0000_0009, '0);

		// Random phases: a new capacity and key pool each phase; every third
		// phase runs without idle gaps.
		issued = 0;
		phase  = 0;
		while (issued < RANDOM_ITEMS) begin
			write_capacity(pick_capacity(phase));
			refill_pool($urandom_range(2, POOL_MAX));
			no_gaps   = (phase % 3 == 2);
			phase_len = $urandom_range(40, 80);
			for (int i = 0; i < phase_len && issued < RANDOM_ITEMS; i++) begin
				send_command($urandom_range(0, 1) ? OP_PUT : OP_GET, draw_key(), draw_value());
				issued++;
			end
			phase++;
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("lru_key_value_cache_unit test passed");
		else
			$display("lru_key_value_cache_unit test failed");
		$finish;
	end

endmodule

/* filelist.f */
rtl/lkv_pkg.sv
rtl/lkv_ram.sv
rtl/lkv_ctrl.sv
rtl/lkv_datapath.sv
rtl/lru_key_value_cache_unit.sv
tb/lru_key_value_cache_unit_test.sv
